FILE: design/btda_pkg.sv
// ----------------------------------------------------------------------------
// btda_pkg
// shared widths, constants and helpers for the binary to decimal ascii block
// ----------------------------------------------------------------------------
package btda_pkg;

  localparam int NUMBER_W       = 64;   // input field width
  localparam int CHAR_W         = 6;    // output character field width
  localparam int BCD_DIGIT_W    = 4;    // bits per decimal digit
  localparam int VALUE_BITS_DEF = 64;   // default converted width

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // decimal digits of 2**w - 1, floor(w * log10(2)) + 1, good for w up to 64
  function automatic int num_digits(input int w);
    return ((w * 1233) >>> 12) + 1;
  endfunction

endpackage

FILE: design/btda_if.sv
// ----------------------------------------------------------------------------
// btda_in_if / btda_out_if
// valid/ready channels for the number input and the digit output
// ----------------------------------------------------------------------------
interface btda_in_if
  import btda_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [NUMBER_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface btda_out_if
  import btda_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

FILE: design/btda_dabble.sv
// ----------------------------------------------------------------------------
// btda_dabble
// one double dabble step: add-3 correction on every digit, then shift a bit in
// ----------------------------------------------------------------------------
module btda_dabble
  import btda_pkg::*;
#(
  parameter int NDIG = num_digits(VALUE_BITS_DEF)
) (
  input  logic [NDIG*BCD_DIGIT_W-1:0] bcd_in,
  input  logic                        bit_in,
  output logic [NDIG*BCD_DIGIT_W-1:0] bcd_out
);

  localparam int BCD_W = NDIG * BCD_DIGIT_W;

  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_in[i*BCD_DIGIT_W +: BCD_DIGIT_W] >= 4'd5) begin
        adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] = bcd_in[i*BCD_DIGIT_W +: BCD_DIGIT_W] + 4'd3;
      end else begin
        adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] = bcd_in[i*BCD_DIGIT_W +: BCD_DIGIT_W];
      end
    end
  end

  assign bcd_out = {adj[BCD_W-2:0], bit_in};

endmodule

FILE: design/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// converts an unsigned binary value to ascii decimal digits, msd first
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  in_chan   in   valid / ready        number[63:0] (low VALUE_BITS used)
//  out_chan  out  valid / ready        digit_char[5:0], last_digit
//
//  one transaction in: accepted while idle, then double dabble over the VALUE_BITS
//  input bits in the shared add-3/shift unit, then leading zeros are stripped
//  and the digits are sent msd first on out_chan
//  in_chan.ready is high only while idle; one value is worked at a time
//  out_chan stalls simply hold the digit in the bcd register
//  rst_n is synchronous, active low, and returns the sequencer to idle
//
module binary_to_decimal_ascii
  import btda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  btda_in_if.sink     in_chan,
  btda_out_if.source  out_chan
);

  // digits needed for the widest value, and register widths that follow
  localparam int NDIG  = num_digits(VALUE_BITS);
  localparam int BCD_W = NDIG * BCD_DIGIT_W;
  localparam int BCW   = $clog2(VALUE_BITS + 1);
  localparam int DCW   = $clog2(NDIG + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_TRIM = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]            state_r,  state_nxt;
  logic [VALUE_BITS-1:0] val_r,    val_nxt;
  logic [BCD_W-1:0]      bcd_r,    bcd_nxt;
  logic [BCW-1:0]        bitcnt_r, bitcnt_nxt;
  logic [DCW-1:0]        dcnt_r,   dcnt_nxt;

  logic [BCD_W-1:0]       bcd_step;
  logic [BCD_DIGIT_W-1:0] top_digit;
  logic                   in_xfer;
  logic                   out_xfer;

  // shared add-3 and shift unit, one input bit per cycle
  btda_dabble #(
    .NDIG (NDIG)
  ) u_dabble (
    .bcd_in  (bcd_r),
    .bit_in  (val_r[VALUE_BITS-1]),
    .bcd_out (bcd_step)
  );

  assign top_digit = bcd_r[BCD_W-1 -: BCD_DIGIT_W];
  assign in_xfer   = in_chan.valid && in_chan.ready;
  assign out_xfer  = out_chan.valid && out_chan.ready;

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = (state_r == S_EMIT);
  assign out_chan.digit_char = ASCII_ZERO | CHAR_W'(top_digit);
  assign out_chan.last_digit = (dcnt_r == DCW'(1));

  always_comb begin
    state_nxt  = state_r;
    val_nxt    = val_r;
    bcd_nxt    = bcd_r;
    bitcnt_nxt = bitcnt_r;
    dcnt_nxt   = dcnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          // bits above VALUE_BITS are dropped here
          val_nxt    = in_chan.number[VALUE_BITS-1:0];
          bcd_nxt    = '0;
          bitcnt_nxt = BCW'(VALUE_BITS);
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt    = bcd_step;
        val_nxt    = {val_r[VALUE_BITS-2:0], 1'b0};
        bitcnt_nxt = bitcnt_r - BCW'(1);
        if (bitcnt_r == BCW'(1)) begin
          dcnt_nxt  = DCW'(NDIG);
          state_nxt = S_TRIM;
        end
      end
      S_TRIM: begin
        // strip leading zeros, always keep the last digit
        if (top_digit == '0 && dcnt_r != DCW'(1)) begin
          bcd_nxt  = {bcd_r[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
          dcnt_nxt = dcnt_r - DCW'(1);
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_xfer) begin
          bcd_nxt  = {bcd_r[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
          dcnt_nxt = dcnt_r - DCW'(1);
          if (dcnt_r == DCW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bitcnt_r <= '0;
      dcnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      bitcnt_r <= bitcnt_nxt;
      dcnt_r   <= dcnt_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    bcd_r <= bcd_nxt;
  end

  // an accepted value always starts the conversion sweep
  a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_CONV && bitcnt_r == BCW'(VALUE_BITS)))
    else $error("conversion did not start after input transaction");

  // the digit flagged last returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_chan.last_digit) |=> (state_r == S_IDLE))
    else $error("block not idle after last digit");

  // every digit sent is a valid bcd digit
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (top_digit <= 4'd9 && dcnt_r != '0))
    else $error("bad digit or empty count while sending");

  // the first digit sent is nonzero unless it is the only one
  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && $past(state_r) == S_TRIM && dcnt_r != DCW'(1))
      |-> (top_digit != '0))
    else $error("leading zero not stripped");

endmodule
